### src/sio_cfg_pkg.sv
// types, constants and tables shared by the super i/o configuration port
package sio_cfg_pkg;

  localparam int NumRegs = 42;
  localparam int IdxW    = $clog2(NumRegs);

  localparam logic [15:0] StrapReset = 16'h0A05;

  // unlock keys, bit 0 comes from register 0ch bit 5
  localparam logic [7:0] KeyHi     = 8'h86;
  localparam logic [7:0] KeyLo     = 8'h88;
  localparam logic [7:0] LockByte  = 8'hAA;
  localparam logic [7:0] Reg06Mask = 8'hF3;
  localparam logic [7:0] IdleByte  = 8'hFF;

  localparam logic [15:0] PortKeyLo  = 16'h0250;
  localparam logic [15:0] PortIdxLo  = 16'h0251;
  localparam logic [15:0] PortDataLo = 16'h0252;
  localparam logic [15:0] PortKeyHi  = 16'h03F0;
  localparam logic [15:0] PortDataHi = 16'h03F1;

  localparam logic [9:0] FdcBase     = 10'h3F0;
  localparam logic [9:0] LptEppMask  = 10'h3F8;
  localparam logic [9:0] LptMask     = 10'h3FC;
  localparam logic [9:0] LptDefault  = 10'h378;
  localparam logic [9:0] ComADefault = 10'h3F8;
  localparam logic [9:0] ComBDefault = 10'h2F8;

  localparam logic [1:0] ClkDiv13 = 2'd0;
  localparam logic [1:0] ClkDiv12 = 2'd1;
  localparam logic [1:0] Clk14M   = 2'd2;

  localparam logic [IdxW-1:0] Reg00 = IdxW'(6'h00);
  localparam logic [IdxW-1:0] Reg03 = IdxW'(6'h03);
  localparam logic [IdxW-1:0] Reg04 = IdxW'(6'h04);
  localparam logic [IdxW-1:0] Reg06 = IdxW'(6'h06);
  localparam logic [IdxW-1:0] Reg07 = IdxW'(6'h07);
  localparam logic [IdxW-1:0] Reg09 = IdxW'(6'h09);
  localparam logic [IdxW-1:0] Reg0A = IdxW'(6'h0A);
  localparam logic [IdxW-1:0] Reg0C = IdxW'(6'h0C);
  localparam logic [IdxW-1:0] Reg0D = IdxW'(6'h0D);
  localparam logic [IdxW-1:0] Reg16 = IdxW'(6'h16);
  localparam logic [IdxW-1:0] Reg18 = IdxW'(6'h18);
  localparam logic [IdxW-1:0] Reg19 = IdxW'(6'h19);
  localparam logic [IdxW-1:0] Reg1E = IdxW'(6'h1E);
  localparam logic [IdxW-1:0] Reg20 = IdxW'(6'h20);
  localparam logic [IdxW-1:0] Reg21 = IdxW'(6'h21);
  localparam logic [IdxW-1:0] Reg22 = IdxW'(6'h22);
  localparam logic [IdxW-1:0] Reg23 = IdxW'(6'h23);
  localparam logic [IdxW-1:0] Reg24 = IdxW'(6'h24);
  localparam logic [IdxW-1:0] Reg25 = IdxW'(6'h25);
  localparam logic [IdxW-1:0] Reg26 = IdxW'(6'h26);
  localparam logic [IdxW-1:0] Reg27 = IdxW'(6'h27);
  localparam logic [IdxW-1:0] Reg28 = IdxW'(6'h28);
  localparam logic [IdxW-1:0] Reg29 = IdxW'(6'h29);

  typedef struct packed {
    logic        is_write;
    logic [15:0] io_port;
    logic [7:0]  write_data;
  } sio_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        port_hit;
    logic        config_open;
    logic [9:0]  fdc_base;
    logic [10:0] lpt_base;
    logic [3:0]  lpt_irq;
    logic [9:0]  com_a_base;
    logic [3:0]  com_a_irq;
    logic [9:0]  com_b_base;
    logic [3:0]  com_b_irq;
    logic [3:0]  uart_clock_sel;
  } sio_out_t;

  // flop copies of the registers that drive the resource decode, the unlock key and the window select
  typedef struct packed {
    logic [7:0] r00;
    logic [7:0] r03;
    logic [7:0] r04;
    logic [7:0] r06;
    logic [7:0] r09;
    logic [7:0] r0c;
    logic [7:0] r16;
    logic [7:0] r19;
    logic [7:0] r20;
    logic [7:0] r23;
    logic [7:0] r24;
    logic [7:0] r25;
    logic [7:0] r28;
  } sio_regs_t;

  typedef struct packed {
    logic [9:0]  fdc_base;
    logic [10:0] lpt_base;
    logic [3:0]  lpt_irq;
    logic [9:0]  com_a_base;
    logic [3:0]  com_a_irq;
    logic [9:0]  com_b_base;
    logic [3:0]  com_b_irq;
    logic [3:0]  uart_clock_sel;
  } sio_map_t;

  function automatic logic [7:0] reset_value(input logic [IdxW-1:0] idx);
    logic [7:0] v;
    case (idx)
      Reg03:   v = 8'h30;
      Reg07:   v = 8'hF5;
      Reg09:   v = StrapReset[15:8];
      Reg0A:   v = 8'h1F;
      Reg0C:   v = 8'h28;
      Reg0D:   v = 8'hA3;
      Reg16:   v = StrapReset[7:0];
      Reg1E:   v = 8'h81;
      Reg20:   v = 8'hFC;
      Reg21:   v = 8'h7C;
      Reg22:   v = 8'hFD;
      Reg23:   v = 8'hDE;
      Reg24:   v = 8'hFE;
      Reg25:   v = 8'hBE;
      Reg26:   v = 8'h24;
      Reg27:   v = 8'h25;
      Reg28:   v = 8'h43;
      Reg29:   v = 8'h62;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] lpt_irq_lookup(input logic [2:0] sel);
    logic [3:0] v;
    case (sel)
      3'd0:    v = 4'd0;
      3'd1:    v = 4'd7;
      3'd2:    v = 4'd9;
      3'd3:    v = 4'd10;
      3'd4:    v = 4'd11;
      3'd5:    v = 4'd14;
      3'd6:    v = 4'd15;
      default: v = 4'd5;
    endcase
    return v;
  endfunction

endpackage

### src/sio_cfg_decode.sv
// resource decode: floppy, parallel and serial bases, irqs and uart clocks
module sio_cfg_decode (
  input  sio_cfg_pkg::sio_regs_t regs_i,
  output sio_cfg_pkg::sio_map_t  map_o
);

  logic       ext, epp, ecp;
  logic [9:0] lpt_p, com_a_p, com_b_p;
  logic [7:0] r27;
  logic [3:0] li;
  logic [1:0] sel_a, sel_b;

  always_comb begin
    ext = regs_i.r09[7];
    epp = ext & regs_i.r00[2];
    ecp = ext & regs_i.r00[3];

    lpt_p = {regs_i.r23, 2'b00} & (epp ? sio_cfg_pkg::LptEppMask : sio_cfg_pkg::LptMask);
    if (lpt_p[9:8] == 2'b00) begin
      lpt_p = sio_cfg_pkg::LptDefault;
    end

    com_a_p = {regs_i.r24[7:1], 3'b000};
    if (com_a_p[9:8] == 2'b00) begin
      com_a_p = sio_cfg_pkg::ComADefault;
    end
    com_b_p = {regs_i.r25[7:1], 3'b000};
    if (com_b_p[9:8] == 2'b00) begin
      com_b_p = sio_cfg_pkg::ComBDefault;
    end

    // register 27h is read-only, so it always holds its reset byte
    r27 = sio_cfg_pkg::reset_value(sio_cfg_pkg::Reg27);
    li  = sio_cfg_pkg::lpt_irq_lookup(r27[7:5]);
    if (li == 4'd0) begin
      li = r27[3:0];
    end

    if (regs_i.r19[1]) begin
      sel_a = sio_cfg_pkg::Clk14M;
    end else if (regs_i.r03[1]) begin
      sel_a = sio_cfg_pkg::ClkDiv12;
    end else begin
      sel_a = sio_cfg_pkg::ClkDiv13;
    end
    if (regs_i.r19[0]) begin
      sel_b = sio_cfg_pkg::Clk14M;
    end else if (regs_i.r03[0]) begin
      sel_b = sio_cfg_pkg::ClkDiv12;
    end else begin
      sel_b = sio_cfg_pkg::ClkDiv13;
    end

    map_o.fdc_base = (!regs_i.r06[3] && regs_i.r20[7:6] != 2'b00) ?
                     sio_cfg_pkg::FdcBase : 10'd0;
    map_o.lpt_base = (!regs_i.r04[7] && regs_i.r23[7:6] != 2'b00) ?
                     {ecp, lpt_p} : 11'd0;
    map_o.lpt_irq  = li;
    map_o.com_a_base = (!regs_i.r04[5] && regs_i.r24[7:6] != 2'b00) ? com_a_p : 10'd0;
    map_o.com_a_irq  = regs_i.r28[7:4];
    map_o.com_b_base = (!regs_i.r04[4] && regs_i.r25[7:6] != 2'b00) ? com_b_p : 10'd0;
    map_o.com_b_irq  = regs_i.r28[3:0];
    map_o.uart_clock_sel = {sel_b, sel_a};
  end

endmodule

### src/super_io_config_port.sv
// super i/o configuration port: key/index/data window and register file
//
//  channel  direction  handshake                payload
//  in       input      in_valid_i / in_stall_o  in_data_i  (sio_in_t)
//  out      output     out_valid_o / out_stall_i out_data_o (sio_out_t)
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (strap word)
//
// one transaction per cycle while the output does not stall; an access is held in the
// input register, then its result in the result register. the register file read port
// is pre-loaded from the next index, so a data read finds its entry already read out.
// reset loads the datasheet defaults at once through per-entry valid bits.
// the input side stalls only while the result register is full and stalled.
module super_io_config_port (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sio_cfg_pkg::sio_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sio_cfg_pkg::sio_out_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [15:0]           cfg_data_i
);

  localparam int IdxW = sio_cfg_pkg::IdxW;
  localparam int NumRegs = sio_cfg_pkg::NumRegs;

  logic                  in_valid_q;
  sio_cfg_pkg::sio_in_t  in_q;
  logic                  out_valid_q;
  sio_cfg_pkg::sio_out_t out_q;
  logic                  advance, in_accept;

  sio_cfg_pkg::sio_regs_t regs_q, regs_d;
  logic [IdxW-1:0]        index_q, index_d;
  logic                   unlocked_q, unlocked_d;
  logic                   guard_q, guard_d;
  logic                   first_key_q, first_key_d;

  logic [7:0]         mem [NumRegs];
  logic [NumRegs-1:0] valid_q;
  logic [7:0]         mem_raw_q, fwd_data_q;
  logic               fwd_q, entry_valid_q;
  logic [7:0]         mem_word;
  logic               mem_we;
  logic [7:0]         mem_wdata;

  logic                 hi, is_key, is_idx, is_data, hit, wr;
  logic [7:0]           key, val, rd, wval, diff, stored;
  sio_cfg_pkg::sio_map_t map;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !in_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // register file entry at the current index, with write-through and reset defaults
  assign mem_word = fwd_q ? fwd_data_q :
                    entry_valid_q ? mem_raw_q : sio_cfg_pkg::reset_value(index_q);

  always_comb begin
    wr  = in_q.is_write;
    val = in_q.write_data;
    hi  = regs_q.r16[0];
    key = (hi ? sio_cfg_pkg::KeyHi : sio_cfg_pkg::KeyLo) | {7'd0, regs_q.r0c[5]};

    if (hi) begin
      is_key  = (in_q.io_port == sio_cfg_pkg::PortKeyHi);
      is_idx  = 1'b0;
      is_data = (in_q.io_port == sio_cfg_pkg::PortDataHi);
    end else begin
      is_key  = (in_q.io_port == sio_cfg_pkg::PortKeyLo);
      is_idx  = (in_q.io_port == sio_cfg_pkg::PortIdxLo);
      is_data = (in_q.io_port == sio_cfg_pkg::PortDataLo);
    end
    hit = is_key || is_idx || is_data;

    regs_d      = regs_q;
    index_d     = index_q;
    unlocked_d  = unlocked_q;
    guard_d     = guard_q;
    first_key_d = first_key_q;
    mem_we      = 1'b0;
    rd          = sio_cfg_pkg::IdleByte;

    wval = val;
    if (index_q == sio_cfg_pkg::Reg06) begin
      wval = val & sio_cfg_pkg::Reg06Mask;
    end
    case (index_q)
      sio_cfg_pkg::Reg09: stored = regs_q.r09;
      sio_cfg_pkg::Reg16: stored = regs_q.r16;
      default:            stored = mem_word;
    endcase
    diff = wval ^ stored;
    if (index_q == sio_cfg_pkg::Reg28) begin
      // a nibble that changes to zero snaps back to its default irq
      if (diff[3:0] != 4'd0 && wval[3:0] == 4'd0) begin
        wval[3:0] = 4'd3;
      end
      if (diff[7:4] != 4'd0 && wval[7:4] == 4'd0) begin
        wval[7:4] = 4'd4;
      end
    end
    mem_wdata = wval;

    if (advance) begin
      if (wr) begin
        if (is_key && !hi) begin
          unlocked_d = (val == key);
        end else if (is_idx) begin
          if (val < 8'(NumRegs)) begin
            index_d = val[IdxW-1:0];
          end
        end else if (is_key) begin
          // high window needs the key twice in a row
          if (val == key && !unlocked_q) begin
            unlocked_d  = first_key_q;
            first_key_d = !first_key_q;
          end else if (unlocked_q) begin
            if (val < 8'(NumRegs)) begin
              index_d = val[IdxW-1:0];
            end
            if (val == sio_cfg_pkg::LockByte) begin
              unlocked_d = 1'b0;
            end
          end else begin
            first_key_d = 1'b0;
          end
        end else if (is_data && unlocked_q && !guard_q &&
                     !(index_q inside {sio_cfg_pkg::Reg26, sio_cfg_pkg::Reg27,
                                       sio_cfg_pkg::Reg29})) begin
          mem_we = 1'b1;
          case (index_q)
            sio_cfg_pkg::Reg00: regs_d.r00 = wval;
            sio_cfg_pkg::Reg03: regs_d.r03 = wval;
            sio_cfg_pkg::Reg04: regs_d.r04 = wval;
            sio_cfg_pkg::Reg06: regs_d.r06 = wval;
            sio_cfg_pkg::Reg09: begin
              regs_d.r09 = wval;
              if (diff[6]) begin
                guard_d = wval[6];
              end
            end
            sio_cfg_pkg::Reg0C: regs_d.r0c = wval;
            sio_cfg_pkg::Reg16: regs_d.r16 = wval;
            sio_cfg_pkg::Reg19: regs_d.r19 = wval;
            sio_cfg_pkg::Reg20: regs_d.r20 = wval;
            sio_cfg_pkg::Reg23: regs_d.r23 = wval;
            sio_cfg_pkg::Reg24: regs_d.r24 = wval;
            sio_cfg_pkg::Reg25: regs_d.r25 = wval;
            sio_cfg_pkg::Reg28: regs_d.r28 = wval;
            default: ;
          endcase
        end
      end else if (unlocked_q) begin
        if ((is_key && hi) || is_idx) begin
          rd = {{(8-IdxW){1'b0}}, index_q};
        end else if (is_data) begin
          if (index_q >= sio_cfg_pkg::Reg18 || !guard_q) begin
            rd = stored;
          end
        end
      end
    end

    if (cfg_valid_i && cfg_ready_o) begin
      regs_d.r09 = cfg_data_i[15:8];
      regs_d.r16 = cfg_data_i[7:0];
    end
  end

  sio_cfg_decode u_decode (
    .regs_i (regs_d),
    .map_o  (map)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      regs_q      <= '{r00: 8'h00, r03: 8'h30, r04: 8'h00, r06: 8'h00,
                       r09: sio_cfg_pkg::StrapReset[15:8], r0c: 8'h28,
                       r16: sio_cfg_pkg::StrapReset[7:0], r19: 8'h00,
                       r20: 8'hFC, r23: 8'hDE, r24: 8'hFE, r25: 8'hBE,
                       r28: 8'h43};
      index_q     <= '0;
      unlocked_q  <= 1'b0;
      guard_q     <= 1'b0;
      first_key_q <= 1'b0;
      valid_q     <= '0;
      fwd_q       <= 1'b0;
      entry_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      regs_q      <= regs_d;
      index_q     <= index_d;
      unlocked_q  <= unlocked_d;
      guard_q     <= guard_d;
      first_key_q <= first_key_d;
      if (mem_we) begin
        valid_q[index_q] <= 1'b1;
      end
      fwd_q         <= mem_we && (index_q == index_d);
      entry_valid_q <= valid_q[index_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    fwd_data_q <= mem_wdata;
    if (advance) begin
      out_q.read_data      <= rd;
      out_q.port_hit       <= hit;
      out_q.config_open    <= unlocked_d;
      out_q.fdc_base       <= map.fdc_base;
      out_q.lpt_base       <= map.lpt_base;
      out_q.lpt_irq        <= map.lpt_irq;
      out_q.com_a_base     <= map.com_a_base;
      out_q.com_a_irq      <= map.com_a_irq;
      out_q.com_b_base     <= map.com_b_base;
      out_q.com_b_irq      <= map.com_b_irq;
      out_q.uart_clock_sel <= map.uart_clock_sel;
    end
  end

  // register file storage
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[index_q] <= mem_wdata;
    end
    mem_raw_q <= mem[index_d];
  end

endmodule

### src/sio_cfg_chk.sv
// port checker for the super i/o configuration port, bound to the top level
module sio_cfg_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input sio_cfg_pkg::sio_out_t out_data_o
);

  // a result waiting on the output holds its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // nothing but ffh comes back while the window is locked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.config_open |-> out_data_o.read_data == 8'hFF)
    else $error("read data returned while locked");

  // a port outside the window never returns data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.port_hit |-> out_data_o.read_data == 8'hFF)
    else $error("read data returned outside the window");

  // floppy base is either off or the fixed primary address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.fdc_base == 10'h000 || out_data_o.fdc_base == 10'h3F0)
    else $error("unexpected floppy base");

endmodule

bind super_io_config_port sio_cfg_chk u_sio_cfg_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### bench/testbench.sv
// checks the super i/o configuration port against a cycle-free model of its register file
`timescale 1ns / 100ps

module testbench;

  localparam int NumRegs = sio_cfg_pkg::NumRegs;
  localparam int IdxW    = sio_cfg_pkg::IdxW;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  sio_cfg_pkg::sio_in_t  in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  sio_cfg_pkg::sio_out_t out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [15:0]           cfg_data_i  = '0;

  super_io_config_port dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the chip state
  logic [7:0]      cfg_regs [NumRegs];
  logic [IdxW-1:0] cur_index;
  logic            ext_open;
  logic            guard_set;
  logic            key_armed;
  logic [3:0]      irq_by_sel [8] = '{4'd0, 4'd7, 4'd9, 4'd10, 4'd11, 4'd14, 4'd15, 4'd5};

  sio_cfg_pkg::sio_out_t bus_replies_due [$];
  int       mismatch_count = 0;
  int       accesses_sent  = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  int       hold_request   = 0;
  int       hold_left      = 0;
  logic     guard_allowed  = 1'b0;

  function automatic void load_strap(input logic [15:0] w);
    cfg_regs[sio_cfg_pkg::Reg09] = w[15:8];
    cfg_regs[sio_cfg_pkg::Reg16] = w[7:0];
  endfunction

  function automatic void reset_model();
    foreach (cfg_regs[i]) cfg_regs[i] = 8'h00;
    cfg_regs[sio_cfg_pkg::Reg03] = 8'h30;
    cfg_regs[sio_cfg_pkg::Reg07] = 8'hF5;
    cfg_regs[sio_cfg_pkg::Reg0A] = 8'h1F;
    cfg_regs[sio_cfg_pkg::Reg0C] = 8'h28;
    cfg_regs[sio_cfg_pkg::Reg0D] = 8'hA3;
    cfg_regs[sio_cfg_pkg::Reg1E] = 8'h81;
    cfg_regs[sio_cfg_pkg::Reg20] = 8'hFC;
    cfg_regs[sio_cfg_pkg::Reg21] = 8'h7C;
    cfg_regs[sio_cfg_pkg::Reg22] = 8'hFD;
    cfg_regs[sio_cfg_pkg::Reg23] = 8'hDE;
    cfg_regs[sio_cfg_pkg::Reg24] = 8'hFE;
    cfg_regs[sio_cfg_pkg::Reg25] = 8'hBE;
    cfg_regs[sio_cfg_pkg::Reg26] = 8'h24;
    cfg_regs[sio_cfg_pkg::Reg27] = 8'h25;
    cfg_regs[sio_cfg_pkg::Reg28] = 8'h43;
    cfg_regs[sio_cfg_pkg::Reg29] = 8'h62;
    load_strap(sio_cfg_pkg::StrapReset);
    cur_index = '0;
    ext_open  = 1'b0;
    guard_set = 1'b0;
    key_armed = 1'b0;
  endfunction

  function automatic void store_register(input logic [7:0] val);
    logic [7:0] v;
    logic [7:0] diff;
    v = val;
    if (!ext_open || guard_set) return;
    if (cur_index == sio_cfg_pkg::Reg26 || cur_index == sio_cfg_pkg::Reg27 ||
        cur_index == sio_cfg_pkg::Reg29) return;
    if (cur_index == sio_cfg_pkg::Reg06) v = v & sio_cfg_pkg::Reg06Mask;
    diff = v ^ cfg_regs[cur_index];
    cfg_regs[cur_index] = v;
    if (cur_index == sio_cfg_pkg::Reg09 && diff[6]) guard_set = v[6];
    if (cur_index == sio_cfg_pkg::Reg28) begin
      // a nibble written to zero snaps back to its default irq
      if (diff[3:0] != 4'h0 && v[3:0] == 4'h0) cfg_regs[sio_cfg_pkg::Reg28][3:0] = 4'h3;
      if (diff[7:4] != 4'h0 && v[7:4] == 4'h0) cfg_regs[sio_cfg_pkg::Reg28][7:4] = 4'h4;
    end
  endfunction

  function automatic logic [9:0] uart_base(input logic off, input logic [7:0] r,
                                           input logic [9:0] dflt);
    logic [9:0] p;
    if (off || r[7:6] == 2'b00) return 10'h000;
    p = {r[7:1], 3'b000};
    if (p < 10'h100 || p > 10'h3F8) p = dflt;
    return p;
  endfunction

  function automatic logic [1:0] uart_clock(input logic fast, input logic div12);
    if (fast) return sio_cfg_pkg::Clk14M;
    if (div12) return sio_cfg_pkg::ClkDiv12;
    return sio_cfg_pkg::ClkDiv13;
  endfunction

  function automatic sio_cfg_pkg::sio_out_t predict_access(input sio_cfg_pkg::sio_in_t acc);
    sio_cfg_pkg::sio_out_t r;
    logic       hi_win, k_port, i_port, d_port, ext, ecp;
    logic [7:0] key, v;
    logic [9:0] p;
    hi_win = cfg_regs[sio_cfg_pkg::Reg16][0];
    key    = (hi_win ? sio_cfg_pkg::KeyHi : sio_cfg_pkg::KeyLo) |
             {7'b0, cfg_regs[sio_cfg_pkg::Reg0C][5]};
    k_port = acc.io_port == (hi_win ? sio_cfg_pkg::PortKeyHi : sio_cfg_pkg::PortKeyLo);
    i_port = !hi_win && acc.io_port == sio_cfg_pkg::PortIdxLo;
    d_port = acc.io_port == (hi_win ? sio_cfg_pkg::PortDataHi : sio_cfg_pkg::PortDataLo);
    v      = acc.write_data;
    r      = '0;
    r.read_data = sio_cfg_pkg::IdleByte;
    if (acc.is_write) begin
      if (k_port && !hi_win) begin
        ext_open = (v == key);
      end else if (i_port) begin
        if (v < NumRegs) cur_index = v[IdxW-1:0];
      end else if (k_port) begin
        if (v == key && !ext_open) begin
          // the high window wants the key twice in a row
          if (key_armed) begin
            ext_open  = 1'b1;
            key_armed = 1'b0;
          end else begin
            key_armed = 1'b1;
          end
        end else if (ext_open) begin
          if (v < NumRegs) cur_index = v[IdxW-1:0];
          if (v == sio_cfg_pkg::LockByte) ext_open = 1'b0;
        end else begin
          key_armed = 1'b0;
        end
      end else if (d_port) begin
        store_register(v);
      end
    end else if (ext_open) begin
      if ((k_port && hi_win) || i_port) begin
        r.read_data = {{(8-IdxW){1'b0}}, cur_index};
      end else if (d_port && (cur_index >= sio_cfg_pkg::Reg18 || !guard_set)) begin
        r.read_data = cfg_regs[cur_index];
      end
    end

    r.port_hit    = k_port || i_port || d_port;
    r.config_open = ext_open;
    if (!cfg_regs[sio_cfg_pkg::Reg06][3] && cfg_regs[sio_cfg_pkg::Reg20][7:6] != 2'b00)
      r.fdc_base = sio_cfg_pkg::FdcBase;
    if (!cfg_regs[sio_cfg_pkg::Reg04][7] && cfg_regs[sio_cfg_pkg::Reg23][7:6] != 2'b00) begin
      ext = cfg_regs[sio_cfg_pkg::Reg09][7];
      ecp = ext && cfg_regs[sio_cfg_pkg::Reg00][3];
      p   = {cfg_regs[sio_cfg_pkg::Reg23], 2'b00} &
            ((ext && cfg_regs[sio_cfg_pkg::Reg00][2]) ? sio_cfg_pkg::LptEppMask :
                                                        sio_cfg_pkg::LptMask);
      if (p < 10'h100) p = sio_cfg_pkg::LptDefault;
      r.lpt_base = {ecp, p};
    end
    r.lpt_irq = irq_by_sel[cfg_regs[sio_cfg_pkg::Reg27][7:5]];
    if (r.lpt_irq == 4'd0) r.lpt_irq = cfg_regs[sio_cfg_pkg::Reg27][3:0];
    r.com_a_base = uart_base(cfg_regs[sio_cfg_pkg::Reg04][5], cfg_regs[sio_cfg_pkg::Reg24],
                             sio_cfg_pkg::ComADefault);
    r.com_b_base = uart_base(cfg_regs[sio_cfg_pkg::Reg04][4], cfg_regs[sio_cfg_pkg::Reg25],
                             sio_cfg_pkg::ComBDefault);
    r.com_a_irq  = cfg_regs[sio_cfg_pkg::Reg28][7:4];
    r.com_b_irq  = cfg_regs[sio_cfg_pkg::Reg28][3:0];
    r.uart_clock_sel = {uart_clock(cfg_regs[sio_cfg_pkg::Reg19][0],
                                   cfg_regs[sio_cfg_pkg::Reg03][0]),
                        uart_clock(cfg_regs[sio_cfg_pkg::Reg19][1],
                                   cfg_regs[sio_cfg_pkg::Reg03][1])};
    return r;
  endfunction

  always @(posedge clk_i) begin : reply_check
    sio_cfg_pkg::sio_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (bus_replies_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none pending, expected nothing, actual %h",
                   $time, out_data_o);
        end else begin
          want = bus_replies_due.pop_front();
          if (want !== out_data_o) begin
            mismatch_count++;
            $display("%0t: result mismatch, expected %h, actual %h",
                     $time, want, out_data_o);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) load_strap(cfg_data_i);
      if (in_valid_i && !in_stall_o) bus_replies_due.push_back(predict_access(in_data_i));
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  function automatic logic [15:0] key_port();
    return cfg_regs[sio_cfg_pkg::Reg16][0] ? sio_cfg_pkg::PortKeyHi : sio_cfg_pkg::PortKeyLo;
  endfunction

  function automatic logic [15:0] index_port();
    return cfg_regs[sio_cfg_pkg::Reg16][0] ? sio_cfg_pkg::PortKeyHi : sio_cfg_pkg::PortIdxLo;
  endfunction

  function automatic logic [15:0] data_port();
    return cfg_regs[sio_cfg_pkg::Reg16][0] ? sio_cfg_pkg::PortDataHi :
                                             sio_cfg_pkg::PortDataLo;
  endfunction

  function automatic logic [7:0] unlock_key();
    return (cfg_regs[sio_cfg_pkg::Reg16][0] ? sio_cfg_pkg::KeyHi : sio_cfg_pkg::KeyLo) |
           {7'b0, cfg_regs[sio_cfg_pkg::Reg0C][5]};
  endfunction

  function automatic sio_cfg_pkg::sio_in_t io_access(input logic wr, input logic [15:0] port,
                                                     input logic [7:0] b);
    sio_cfg_pkg::sio_in_t a;
    a.is_write   = wr;
    a.io_port    = port;
    a.write_data = b;
    return a;
  endfunction

  // called just after a falling edge, returns just after the falling edge
  // that follows acceptance, so the shadow state is settled in between
  task automatic send_access(input sio_cfg_pkg::sio_in_t acc);
    sio_cfg_pkg::sio_in_t t;
    t = acc;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    // keep the write-protect bit of register 09h unchanged until its own test
    if (!guard_allowed && t.is_write && ext_open && t.io_port == data_port() &&
        cur_index == sio_cfg_pkg::Reg09)
      t.write_data[6] = cfg_regs[sio_cfg_pkg::Reg09][6];
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    accesses_sent++;
    @(negedge clk_i);
  endtask

  task automatic select_register(input logic [IdxW-1:0] idx);
    send_access(io_access(1'b1, index_port(), {{(8-IdxW){1'b0}}, idx}));
  endtask

  task automatic open_window();
    logic [7:0] key;
    key = unlock_key();
    send_access(io_access(1'b1, key_port(), key));
    if (cfg_regs[sio_cfg_pkg::Reg16][0]) send_access(io_access(1'b1, key_port(), key));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (bus_replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_strap(input logic [15:0] w);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_sequence();
    int         c;
    int         n;
    logic [7:0] b;
    logic [15:0] near_ports [8];
    near_ports = '{sio_cfg_pkg::PortKeyLo, sio_cfg_pkg::PortIdxLo, sio_cfg_pkg::PortDataLo,
                   sio_cfg_pkg::PortKeyHi, sio_cfg_pkg::PortDataHi,
                   16'h024F, 16'h0253, 16'h03F2};
    c = $urandom_range(0, 99);
    if (!ext_open && $urandom_range(0, 99) < 70) c = 0;
    if (c < 20) begin
      // now and then a broken key pair first
      if (cfg_regs[sio_cfg_pkg::Reg16][0] && $urandom_range(0, 7) == 0) begin
        send_access(io_access(1'b1, key_port(), unlock_key()));
        send_access(io_access(1'b1, key_port(), 8'($urandom)));
      end
      open_window();
    end else if (c < 60) begin
      b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NumRegs - 1));
      send_access(io_access(1'b1, index_port(), b));
      n = $urandom_range(1, 3);
      repeat (n) send_access(io_access(1'($urandom_range(0, 1)), data_port(), 8'($urandom)));
    end else if (c < 68) begin
      send_access(io_access(1'b0, $urandom_range(0, 1) ? index_port() : key_port(),
                            8'($urandom)));
    end else if (c < 75) begin
      b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : sio_cfg_pkg::LockByte;
      send_access(io_access(1'b1, key_port(), b));
    end else if (c < 88) begin
      send_access(io_access(1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom)));
    end else begin
      send_access(io_access(1'($urandom_range(0, 1)), near_ports[$urandom_range(0, 7)],
                            8'($urandom)));
    end
  endtask

  task automatic run_random(input int n);
    int target;
    target = accesses_sent + n;
    while (accesses_sent < target) random_sequence();
  endtask

  // reset window is 3f0h: locked read, broken and good double key
  task automatic test_unlock_keys();
    send_access(io_access(1'b0, data_port(), 8'h00));
    send_access(io_access(1'b1, key_port(), unlock_key()));
    send_access(io_access(1'b1, key_port(), 8'h55));
    open_window();
    send_access(io_access(1'b0, index_port(), 8'h00));
    send_access(io_access(1'b1, key_port(), unlock_key()));
  endtask

  task automatic test_register_rules();
    select_register(sio_cfg_pkg::Reg28);
    send_access(io_access(1'b1, data_port(), 8'h00));
    send_access(io_access(1'b1, data_port(), 8'h50));
    send_access(io_access(1'b0, data_port(), 8'h00));
    select_register(sio_cfg_pkg::Reg29);
    send_access(io_access(1'b1, data_port(), 8'hFF));
    select_register(sio_cfg_pkg::Reg06);
    send_access(io_access(1'b1, data_port(), 8'hFF));
    send_access(io_access(1'b1, index_port(), 8'h2A));
    send_access(io_access(1'b0, data_port(), 8'h00));
    // move the window down to 250h while unlocked
    select_register(sio_cfg_pkg::Reg16);
    send_access(io_access(1'b1, data_port(), 8'h00));
    send_access(io_access(1'b0, key_port(), 8'h00));
    send_access(io_access(1'b0, index_port(), 8'h00));
    send_access(io_access(1'b1, key_port(), sio_cfg_pkg::LockByte));
    send_access(io_access(1'b0, data_port(), 8'h00));
    open_window();
    send_access(io_access(1'b0, 16'hFFFF, 8'h00));
    send_access(io_access(1'b1, 16'h0000, 8'h00));
    send_access(io_access(1'b1, 16'hFFFF, 8'hFF));
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 150;
    run_random(30);
    wait_drained();
    run_random(10);
  endtask

  task automatic test_random_phases();
    logic [15:0] strap_values [5];
    int          send_mix [5];
    int          recv_mix [5];
    strap_values = '{16'hFFFF, 16'h0000, 16'h0A04, 16'h8A05, 16'h0000};
    send_mix     = '{0, 49, 0, 27, 0};
    recv_mix     = '{0, 0, 49, 27, 0};
    strap_values[4] = 16'($urandom);
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      write_strap(strap_values[ph]);
      send_idle_pct  = send_mix[ph];
      recv_stall_pct = recv_mix[ph];
      run_random(150);
    end
  endtask

  // write protect can only be undone by reset, so it runs last
  task automatic test_write_guard();
    wait_drained();
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    guard_allowed  = 1'b1;
    if (!ext_open) open_window();
    select_register(sio_cfg_pkg::Reg09);
    send_access(io_access(1'b1, data_port(), cfg_regs[sio_cfg_pkg::Reg09] & 8'hBF));
    send_access(io_access(1'b1, data_port(), cfg_regs[sio_cfg_pkg::Reg09] | 8'h40));
    send_access(io_access(1'b0, data_port(), 8'h00));
    select_register(sio_cfg_pkg::Reg28);
    send_access(io_access(1'b1, data_port(), 8'h00));
    send_access(io_access(1'b0, data_port(), 8'h00));
    run_random(20);
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_unlock_keys();
    test_register_rules();
    test_backpressure();
    test_random_phases();
    test_write_guard();
    wait_drained();
    if (mismatch_count == 0 && bus_replies_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
